/* src/cab_pkg.sv */
// -----------------------------------------------------------------------------
// cab_pkg: shared types and constants for the crop-and-bin pixel block
// Register indexes, sequencer states, result record and default sizes.
// -----------------------------------------------------------------------------
package cab_pkg;

   localparam int DEF_MAX_FRAME_WIDTH  = 4096;
   localparam int DEF_MAX_FRAME_HEIGHT = 4096;
   localparam int DEF_MAX_BIN          = 16;
   localparam int DEF_PIXEL_BITS       = 16;

   localparam int PIXEL_FIELD_BITS = 16;
   localparam int SUM_BITS         = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;
   localparam int FIFO_DEPTH       = 4;

   localparam logic [12:0] RST_FRAME_WIDTH  = 13'd4096;
   localparam logic [12:0] RST_FRAME_HEIGHT = 13'd4096;
   localparam logic [4:0]  RST_BIN_FACTOR   = 5'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_CROP_ENABLE  = 3'd2,
      CSR_CROP_X_A     = 3'd3,
      CSR_CROP_X_B     = 3'd4,
      CSR_CROP_Y_A     = 3'd5,
      CSR_CROP_Y_B     = 3'd6,
      CSR_BIN_FACTOR   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_WINDOW,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RUN
   } seq_state_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] binned_sum;
      logic                row_end;
      logic                frame_end;
   } result_type;

endpackage

/* src/cab_ram.sv */
// -----------------------------------------------------------------------------
// cab_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// -----------------------------------------------------------------------------
module cab_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 4096,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cab_divider.sv */
// -----------------------------------------------------------------------------
// cab_divider: restoring unsigned divider
// One quotient bit per cycle; quotient and remainder valid once busy drops.
// -----------------------------------------------------------------------------
module cab_divider #(
   parameter int  NUM_W = 13,
   parameter int  DEN_W = 5,
   localparam int CNT_W = $clog2(NUM_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         num_in = {num_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

/* src/crop_and_bin_pixels.sv */
// -----------------------------------------------------------------------------
// crop_and_bin_pixels: crop a raw frame and sum square pixel blocks
// Streams raw pixels in, streams one 16-bit block sum out per complete block.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries raw pixels of a full sensor frame in raster order, one
//   request per pixel; req_tuser marks the first pixel of a frame and
//   restarts the position. rsp_* carries one sum per complete bin block of
//   the window in raster order of blocks; rsp_tlast flags the last block of
//   an output row and rsp_tuser the last block of the frame.
//   csr_* writes the configuration registers; write them only while idle.
// Throughput: one pixel per clock unless stalled. A block sum leaves the
//   accumulate stage for the output queue after the request with the block's
//   bottom-right pixel. The column sums live in one RAM with registered read
//   data; the pixel and accumulate stages read-modify-write it with forwarding.
// Reset: the accumulator RAM is cleared, one entry a cycle, over all
//   MAX_FRAME_WIDTH entries, then the window is set up. After reset and after
//   every register write, the window setup runs through its window, divider
//   start and divider wait states; req_tready is low meanwhile.
// Stall: a four-entry output queue absorbs results, which pile up while
//   rsp_tready stays low; req_tready drops once three are queued or in flight.
// -----------------------------------------------------------------------------
module crop_and_bin_pixels
   import cab_pkg::*;
#(
   parameter int MAX_FRAME_WIDTH  = DEF_MAX_FRAME_WIDTH,
   parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT,
   parameter int MAX_BIN          = DEF_MAX_BIN,
   parameter int PIXEL_BITS       = DEF_PIXEL_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // pixel requests
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [PIXEL_FIELD_BITS-1:0] req_tdata,   // [15:0] pixel_value
   input  logic                        req_tuser,   // [0] frame_start
   // block sums
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [SUM_BITS-1:0]         rsp_tdata,   // [15:0] binned_sum
   output logic                        rsp_tlast,   // row_end
   output logic                        rsp_tuser,   // [0] frame_end
   // configuration writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data
);

   localparam int XW  = $clog2(MAX_FRAME_WIDTH);
   localparam int XSW = $clog2(MAX_FRAME_WIDTH + 1);
   localparam int YW  = $clog2(MAX_FRAME_HEIGHT);
   localparam int YSW = $clog2(MAX_FRAME_HEIGHT + 1);
   localparam int BSW = $clog2(MAX_BIN + 1);
   localparam int BPW = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
   localparam int FPW = $clog2(FIFO_DEPTH);
   localparam int FCW = $clog2(FIFO_DEPTH + 1);
   localparam logic [PIXEL_FIELD_BITS-1:0] PIX_MASK =
      PIXEL_FIELD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [12:0] frame_width_ff, frame_height_ff;
   logic        crop_enable_ff;
   logic [15:0] crop_x_a_ff, crop_x_b_ff, crop_y_a_ff, crop_y_b_ff;
   logic [4:0]  bin_factor_ff;
   logic        csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         crop_enable_ff  <= 1'b0;
         crop_x_a_ff     <= '0;
         crop_x_b_ff     <= '0;
         crop_y_a_ff     <= '0;
         crop_y_b_ff     <= '0;
         bin_factor_ff   <= RST_BIN_FACTOR;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[12:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[12:0];
            CSR_CROP_ENABLE:  crop_enable_ff  <= csr_data[0];
            CSR_CROP_X_A:     crop_x_a_ff     <= csr_data;
            CSR_CROP_X_B:     crop_x_b_ff     <= csr_data;
            CSR_CROP_Y_A:     crop_y_a_ff     <= csr_data;
            CSR_CROP_Y_B:     crop_y_b_ff     <= csr_data;
            CSR_BIN_FACTOR:   bin_factor_ff   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Window setup: saturate sizes, clamp and order the corners
   // ---------------------------------------------------------------------------
   function automatic logic [31:0] clamp_corner(input logic [15:0] corner,
                                                input logic [31:0] size);
      logic [31:0] v;
      v = 32'(corner);
      if (corner[15]) begin
         return 32'd0;
      end else if (v > size - 32'd1) begin
         return size - 32'd1;
      end
      return v;
   endfunction

   function automatic logic [31:0] sat_range(input logic [31:0] v,
                                             input logic [31:0] maxv);
      if (v == 32'd0) begin
         return 32'd1;
      end else if (v > maxv) begin
         return maxv;
      end
      return v;
   endfunction

   logic [31:0] fw_sat, fh_sat, bin_sat;
   logic [31:0] xa, xb, ya, yb, x_lo, x_hi, y_lo, y_hi;

   always_comb begin
      fw_sat  = sat_range(32'(frame_width_ff), 32'(MAX_FRAME_WIDTH));
      fh_sat  = sat_range(32'(frame_height_ff), 32'(MAX_FRAME_HEIGHT));
      bin_sat = sat_range(32'(bin_factor_ff), 32'(MAX_BIN));
      xa = clamp_corner(crop_x_a_ff, fw_sat);
      xb = clamp_corner(crop_x_b_ff, fw_sat);
      ya = clamp_corner(crop_y_a_ff, fh_sat);
      yb = clamp_corner(crop_y_b_ff, fh_sat);
      if (crop_enable_ff) begin
         x_lo = (xa > xb) ? xb : xa;
         x_hi = (xa > xb) ? xa : xb;
         y_lo = (ya > yb) ? yb : ya;
         y_hi = (ya > yb) ? ya : yb;
      end else begin
         x_lo = 32'd0;
         x_hi = fw_sat - 32'd1;
         y_lo = 32'd0;
         y_hi = fh_sat - 32'd1;
      end
   end

   logic [XSW-1:0] fw_s_ff, xspan_ff, wb_ff;
   logic [YSW-1:0] fh_s_ff, yspan_ff, hb_ff;
   logic [XW-1:0]  xlo_ff;
   logic [YW-1:0]  ylo_ff;
   logic [BSW-1:0] bin_s_ff;
   logic [BPW-1:0] bin_m1_ff;

   seq_state_type state_ff, state_in;
   logic [XW-1:0] clr_addr_ff;

   // ---------------------------------------------------------------------------
   // Dividers: block counts of the window and block position of the pixel
   // ---------------------------------------------------------------------------
   logic           div_start;
   logic           div_busy_xs, div_busy_xp, div_busy_ys, div_busy_yp, div_done;
   logic [XSW-1:0] xs_quot, xp_quot, xp_num;
   logic [YSW-1:0] ys_quot, yp_quot, yp_num;
   logic [BSW-1:0] xs_rem, xp_rem, ys_rem, yp_rem;

   logic [XW-1:0]  col_ff, col_in, bx_ff, bx_in;
   logic [YW-1:0]  row_ff, row_in, by_ff, by_in;
   logic [BPW-1:0] cp_ff, cp_in, rp_ff, rp_in;

   assign div_start = (state_ff == ST_DIV_START);
   assign div_done  = !(div_busy_xs || div_busy_xp || div_busy_ys || div_busy_yp);
   assign xp_num    = (col_ff >= xlo_ff) ? XSW'(col_ff - xlo_ff) : '0;
   assign yp_num    = (row_ff >= ylo_ff) ? YSW'(row_ff - ylo_ff) : '0;

   cab_divider #(.NUM_W(XSW), .DEN_W(BSW)) u_div_xspan (
      .clock(clock), .reset(reset), .start(div_start), .num(xspan_ff),
      .den(bin_s_ff), .busy(div_busy_xs), .quot(xs_quot), .rem(xs_rem)
   );

   cab_divider #(.NUM_W(XSW), .DEN_W(BSW)) u_div_xpos (
      .clock(clock), .reset(reset), .start(div_start), .num(xp_num),
      .den(bin_s_ff), .busy(div_busy_xp), .quot(xp_quot), .rem(xp_rem)
   );

   cab_divider #(.NUM_W(YSW), .DEN_W(BSW)) u_div_yspan (
      .clock(clock), .reset(reset), .start(div_start), .num(yspan_ff),
      .den(bin_s_ff), .busy(div_busy_ys), .quot(ys_quot), .rem(ys_rem)
   );

   cab_divider #(.NUM_W(YSW), .DEN_W(BSW)) u_div_ypos (
      .clock(clock), .reset(reset), .start(div_start), .num(yp_num),
      .den(bin_s_ff), .busy(div_busy_yp), .quot(yp_quot), .rem(yp_rem)
   );

   // window registers load in their own state; block counts when division ends
   always_ff @(posedge clock) begin
      if (state_ff == ST_WINDOW) begin
         fw_s_ff   <= XSW'(fw_sat);
         fh_s_ff   <= YSW'(fh_sat);
         bin_s_ff  <= BSW'(bin_sat);
         bin_m1_ff <= BPW'(bin_sat - 32'd1);
         xlo_ff    <= XW'(x_lo);
         ylo_ff    <= YW'(y_lo);
         xspan_ff  <= XSW'(x_hi - x_lo + 32'd1);
         yspan_ff  <= YSW'(y_hi - y_lo + 32'd1);
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         wb_ff <= xs_quot;
         hb_ff <= ys_quot;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer: clear pass, window setup, then pixel streaming
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == XW'(MAX_FRAME_WIDTH - 1)) begin
               state_in = ST_WINDOW;
            end
         end
         ST_WINDOW:    state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_WINDOW;
      endcase
      // a register write outside the clear pass restarts the window setup
      if (csr_we && state_ff != ST_CLEAR) begin
         state_in = ST_WINDOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Pixel stage: position tracking, horizontal sum, accumulator read
   // ---------------------------------------------------------------------------
   logic                        req_accept;
   logic [XW-1:0]               c_eff, bx_eff;
   logic [YW-1:0]               r_eff, by_eff;
   logic [BPW-1:0]              cp_eff, rp_eff;
   logic [XSW-1:0]              c1;
   logic [YSW-1:0]              r1;
   logic                        x_in_win, y_in_win, pix_valid;
   logic [PIXEL_FIELD_BITS-1:0] pix;
   logic [SUM_BITS-1:0]         hsum_ff, hsum_in, hsum_next;
   logic                        acc_wr, emit, blk_row_end, blk_frame_end;
   logic [FCW-1:0]              occ_ff, occ_in;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_RUN)
                       && ((occ_ff + FCW'(s1_emit_ff)) <= FCW'(FIFO_DEPTH - 2));

   always_comb begin
      // frame start forces the column-zero, row-zero position
      c_eff  = req_tuser ? '0 : col_ff;
      r_eff  = req_tuser ? '0 : row_ff;
      cp_eff = req_tuser ? '0 : cp_ff;
      bx_eff = req_tuser ? '0 : bx_ff;
      rp_eff = req_tuser ? '0 : rp_ff;
      by_eff = req_tuser ? '0 : by_ff;

      x_in_win  = (c_eff >= xlo_ff) && (XSW'(bx_eff) < wb_ff);
      y_in_win  = (r_eff >= ylo_ff) && (YSW'(by_eff) < hb_ff);
      pix_valid = req_accept && x_in_win && y_in_win;
      pix       = req_tdata & PIX_MASK;
      hsum_next = (cp_eff == '0) ? SUM_BITS'(pix) : hsum_ff + SUM_BITS'(pix);
      acc_wr    = pix_valid && (cp_eff == bin_m1_ff);
      emit      = acc_wr && (rp_eff == bin_m1_ff);
      blk_row_end   = (XSW'(bx_eff) == wb_ff - 1'b1);
      blk_frame_end = blk_row_end && (YSW'(by_eff) == hb_ff - 1'b1);

      hsum_in = pix_valid ? hsum_next : hsum_ff;

      c1 = XSW'(c_eff) + 1'b1;
      r1 = YSW'(r_eff) + 1'b1;

      col_in = col_ff;
      row_in = row_ff;
      cp_in  = cp_ff;
      bx_in  = bx_ff;
      rp_in  = rp_ff;
      by_in  = by_ff;

      if (state_ff == ST_DIV_WAIT && div_done) begin
         // resync block counters to the held position
         bx_in = XW'(xp_quot);
         cp_in = BPW'(xp_rem);
         by_in = YW'(yp_quot);
         rp_in = BPW'(yp_rem);
      end else if (req_accept) begin
         if (c1 >= fw_s_ff) begin
            col_in = '0;
            cp_in  = '0;
            bx_in  = '0;
            if (r1 >= fh_s_ff) begin
               row_in = '0;
               rp_in  = '0;
               by_in  = '0;
            end else begin
               row_in = YW'(r1);
               if (r_eff < ylo_ff) begin
                  rp_in = '0;
                  by_in = '0;
               end else if (rp_eff == bin_m1_ff) begin
                  rp_in = '0;
                  by_in = by_eff + 1'b1;
               end else begin
                  rp_in = rp_eff + 1'b1;
                  by_in = by_eff;
               end
            end
         end else begin
            col_in = XW'(c1);
            row_in = r_eff;
            rp_in  = rp_eff;
            by_in  = by_eff;
            if (c_eff < xlo_ff) begin
               cp_in = '0;
               bx_in = '0;
            end else if (cp_eff == bin_m1_ff) begin
               cp_in = '0;
               bx_in = bx_eff + 1'b1;
            end else begin
               cp_in = cp_eff + 1'b1;
               bx_in = bx_eff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cp_ff   <= '0;
         bx_ff   <= '0;
         rp_ff   <= '0;
         by_ff   <= '0;
         hsum_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cp_ff   <= cp_in;
         bx_ff   <= bx_in;
         rp_ff   <= rp_in;
         by_ff   <= by_in;
         hsum_ff <= hsum_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Accumulate stage: add the RAM word, write back, queue the result
   // ---------------------------------------------------------------------------
   logic                s1_wr_ff, s1_emit_ff, s1_first_ff, s1_re_ff, s1_fe_ff;
   logic                s1_fwd_ff;
   logic [XW-1:0]       s1_addr_ff;
   logic [SUM_BITS-1:0] s1_hsum_ff, s1_fwd_data_ff;
   logic [SUM_BITS-1:0] ram_rd_data, acc_base, acc_new;
   logic                ram_wr_en;
   logic [XW-1:0]       ram_wr_addr;
   logic [SUM_BITS-1:0] ram_wr_data;

   // take the registered word of the last accumulator write instead of the stale RAM read
   assign acc_base = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign acc_new  = s1_first_ff ? s1_hsum_ff : acc_base + s1_hsum_ff;

   assign ram_wr_en   = (state_ff == ST_CLEAR) || s1_wr_ff;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : s1_addr_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : acc_new;

   cab_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_FRAME_WIDTH)) u_col_acc (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (acc_wr),
      .rd_addr(bx_eff),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_wr_ff   <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else begin
         s1_wr_ff   <= acc_wr;
         s1_emit_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff     <= bx_eff;
      s1_hsum_ff     <= hsum_next;
      s1_first_ff    <= (rp_eff == '0);
      s1_re_ff       <= blk_row_end;
      s1_fe_ff       <= blk_frame_end;
      s1_fwd_ff      <= s1_wr_ff && (s1_addr_ff == bx_eff);
      s1_fwd_data_ff <= acc_new;
   end

   // ---------------------------------------------------------------------------
   // Output queue
   // ---------------------------------------------------------------------------
   result_type     fifo_ff [FIFO_DEPTH];
   result_type     push_item, head_item;
   logic [FPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic           push, pop;

   assign push      = s1_emit_ff;
   assign pop       = rsp_tvalid && rsp_tready;
   assign push_item = '{binned_sum: acc_new, row_end: s1_re_ff, frame_end: s1_fe_ff};
   assign head_item = fifo_ff[rd_ptr_ff];

   always_comb begin
      occ_in = occ_ff + FCW'(push) - FCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         occ_ff <= occ_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_tvalid = (occ_ff != '0);
   assign rsp_tdata  = head_item.binned_sum;
   assign rsp_tlast  = head_item.row_end;
   assign rsp_tuser  = head_item.frame_end;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FCW'(FIFO_DEPTH))
      else $error("output queue overflow");

   a_emit_has_write: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> s1_wr_ff)
      else $error("result queued without accumulator update");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cp_ff <= bin_m1_ff && rp_ff <= bin_m1_ff))
      else $error("bin phase beyond bin size");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !s1_wr_ff)
      else $error("accumulator write during clear pass");

endmodule
